/* hw/rtl/lcd_pkg.sv */
// ----------------------------------------------------------------------------
// Light change detector package
// Shared widths, constants, register codes and structs for the detector.
// ----------------------------------------------------------------------------
package lcd_pkg;

   // History geometry
   localparam int HISTORY_DEPTH = 10;
   localparam int SAMPLE_W      = 10;
   localparam int SUM_W         = $clog2(((2 ** SAMPLE_W) - 1) * HISTORY_DEPTH + 1);
   localparam int TICK_W        = 9;
   localparam int DIFF_W        = SAMPLE_W + 2;

   // Reciprocal of the depth; exact for every sum value up to 2**SUM_W
   localparam int RECIP_SHIFT = SUM_W + 5;
   localparam int RECIP_W     = RECIP_SHIFT;
   localparam int PROD_W      = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((2 ** RECIP_SHIFT) + HISTORY_DEPTH - 1) / HISTORY_DEPTH);

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 10;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ADD_THRESHOLD = 2'd0,
      CSR_ON_THRESHOLD  = 2'd1,
      CSR_DECIMATION    = 2'd2
   } lcd_csr_index_type;

   // Register reset values
   localparam logic [SAMPLE_W-1:0] ADD_THRESHOLD_RESET = SAMPLE_W'(6);
   localparam logic [SAMPLE_W-1:0] ON_THRESHOLD_RESET  = SAMPLE_W'(10);
   localparam logic [TICK_W-1:0]   DECIMATION_RESET    = TICK_W'(300);

   // Input command codes
   typedef enum logic {
      CMD_TICK = 1'b0,
      CMD_FILL = 1'b1
   } lcd_cmd_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] add_threshold;
      logic [SAMPLE_W-1:0] on_threshold;
      logic [TICK_W-1:0]   decimation;
   } lcd_cfg_type;

   // Control handed from the evaluator to the history cells
   typedef struct packed {
      logic shift;
      logic fill;
   } lcd_cell_ctrl_type;

   typedef struct packed {
      logic screen_on;
      logic sample_added;
      logic evaluated;
   } lcd_result_type;

endpackage

/* hw/rtl/lcd_req_if.sv */
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying a command and a light sensor sample.
// ----------------------------------------------------------------------------
interface lcd_req_if
   import lcd_pkg::*;
;
   logic                valid;
   logic                ready;
   logic                command;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, command, sample, input ready);
   modport sink   (input valid, command, sample, output ready);
endinterface

/* hw/rtl/lcd_rsp_if.sv */
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying the detection flags of one transaction.
// ----------------------------------------------------------------------------
interface lcd_rsp_if;
   logic valid;
   logic ready;
   logic screen_on;
   logic sample_added;
   logic evaluated;

   modport source (output valid, screen_on, sample_added, evaluated, input ready);
   modport sink   (input valid, screen_on, sample_added, evaluated, output ready);
endinterface

/* hw/rtl/lcd_cell.sv */
// ----------------------------------------------------------------------------
// History cell
// One baseline history entry; loads the sample on fill or takes its
// neighbor's entry on shift.
// ----------------------------------------------------------------------------
module lcd_cell
   import lcd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  lcd_cell_ctrl_type   ctrl,
   input  logic [SAMPLE_W-1:0] sample,
   input  logic [SAMPLE_W-1:0] neighbor,
   output logic [SAMPLE_W-1:0] entry
);

   logic [SAMPLE_W-1:0] entry_ff;
   logic [SAMPLE_W-1:0] entry_in;

   // next entry: fill wins, shift pulls from the newer neighbor
   always_comb begin
      priority if (ctrl.fill) begin
         entry_in = sample;
      end else if (ctrl.shift) begin
         entry_in = neighbor;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

/* hw/rtl/lcd_eval.sv */
// ----------------------------------------------------------------------------
// Evaluator
// Decimation counter, running sum, average and threshold compares.
// ----------------------------------------------------------------------------
module lcd_eval
   import lcd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic                command,
   input  logic [SAMPLE_W-1:0] sample,
   input  logic [SAMPLE_W-1:0] oldest,
   input  lcd_cfg_type         cfg,
   output lcd_cell_ctrl_type   ctrl,
   output lcd_result_type      result
);

   logic [TICK_W-1:0]   tick_count_ff;
   logic [TICK_W-1:0]   tick_count_in;
   logic [SUM_W-1:0]    sum_ff;
   logic [SUM_W-1:0]    sum_in;
   logic [TICK_W:0]     next_tick;
   logic                evaluate;
   logic [PROD_W-1:0]   prod;
   logic [SAMPLE_W-1:0] avg;
   logic signed [DIFF_W-1:0] diff;
   logic                add_hit;
   logic                on_hit;
   logic                is_fill;
   logic [SUM_W-1:0]    fill_sum;

   assign is_fill = (lcd_cmd_type'(command) == CMD_FILL);

   // decimation: evaluate when the incremented count reaches or passes the setting
   assign next_tick = {1'b0, tick_count_ff} + (TICK_W + 1)'(1);
   assign evaluate  = !is_fill && (next_tick >= {1'b0, cfg.decimation});

   // average = sum / depth via reciprocal multiply
   assign prod = PROD_W'(sum_ff) * PROD_W'(RECIP);
   assign avg  = prod[RECIP_SHIFT +: SAMPLE_W];

   // signed sample minus average against the thresholds
   assign diff    = $signed({2'b00, sample}) - $signed({2'b00, avg});
   assign add_hit = evaluate && (diff < $signed({2'b00, cfg.add_threshold}));
   assign on_hit  = evaluate && !add_hit && (diff > $signed({2'b00, cfg.on_threshold}));

   assign fill_sum = SUM_W'(SUM_W'(sample) * SUM_W'(HISTORY_DEPTH));

   // next state of the counter and running sum
   always_comb begin
      tick_count_in = tick_count_ff;
      sum_in        = sum_ff;
      if (accept) begin
         if (is_fill) begin
            sum_in = fill_sum;
         end else begin
            tick_count_in = evaluate ? '0 : next_tick[TICK_W-1:0];
            if (add_hit) begin
               sum_in = sum_ff - SUM_W'(oldest) + SUM_W'(sample);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff <= '0;
         sum_ff        <= '0;
      end else begin
         tick_count_ff <= tick_count_in;
         sum_ff        <= sum_in;
      end
   end

   // outputs
   assign ctrl.fill           = accept && is_fill;
   assign ctrl.shift          = accept && add_hit;
   assign result.screen_on    = on_hit;
   assign result.sample_added = add_hit;
   assign result.evaluated    = evaluate;

   // fill loads the sum with depth times the sample
   assert property (@(posedge clock) disable iff (reset)
      (accept && is_fill) |=> (sum_ff == SUM_W'($past(sample) * HISTORY_DEPTH)))
      else $error("running sum wrong after fill");

   // a skipped tick advances the count by one
   assert property (@(posedge clock) disable iff (reset)
      (accept && !is_fill && !evaluate)
      |=> (tick_count_ff == $past(tick_count_ff) + TICK_W'(1)))
      else $error("tick count did not advance");

   // an evaluated tick restarts the count
   assert property (@(posedge clock) disable iff (reset)
      (accept && evaluate) |=> (tick_count_ff == '0))
      else $error("tick count not cleared on evaluation");

   // a fill leaves the count alone
   assert property (@(posedge clock) disable iff (reset)
      (accept && is_fill) |=> (tick_count_ff == $past(tick_count_ff)))
      else $error("tick count changed on fill");

endmodule

/* hw/rtl/light_change_detector.sv */
// ----------------------------------------------------------------------------
// Light change detector
// Baseline tracking of a light sensor with screen-on detection.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock while the response side keeps up,
// and returns one response per transaction from an output register in the
// cycle after it is accepted; the request side stays ready while that register
// is empty or being drained. The cycle is set by the evaluator path: a reciprocal
// multiply of the running sum for the average, the signed threshold
// compares and the running-sum update. The baseline history is a row of
// cells that shift toward the oldest entry when a sample joins, and are all
// loaded on a fill command. History and sum are cleared by reset; there is
// no clearing pass. Configuration writes take effect on the next cycle and
// writes to an unknown index are ignored.
module light_change_detector
   import lcd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   lcd_req_if.sink               req_chan,
   lcd_rsp_if.source             rsp_chan,
   input  logic                  csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   lcd_cfg_type         cfg_ff;
   lcd_cfg_type         cfg_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   lcd_result_type      rsp_result_ff;
   lcd_result_type      rsp_result_in;
   logic                accept;
   lcd_cell_ctrl_type   ctrl;
   lcd_result_type      result;
   logic [SAMPLE_W-1:0] hist [HISTORY_DEPTH];

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (lcd_csr_index_type'(csr_index))
            CSR_ADD_THRESHOLD: cfg_in.add_threshold = csr_write_data[SAMPLE_W-1:0];
            CSR_ON_THRESHOLD:  cfg_in.on_threshold  = csr_write_data[SAMPLE_W-1:0];
            CSR_DECIMATION:    cfg_in.decimation    = csr_write_data[TICK_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.add_threshold <= ADD_THRESHOLD_RESET;
         cfg_ff.on_threshold  <= ON_THRESHOLD_RESET;
         cfg_ff.decimation    <= DECIMATION_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // handshake: accept while the output register is free or draining
   assign req_chan.ready = !reset && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;

   // evaluator
   lcd_eval u_eval (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .command (req_chan.command),
      .sample  (req_chan.sample),
      .oldest  (hist[0]),
      .cfg     (cfg_ff),
      .ctrl    (ctrl),
      .result  (result)
   );

   // history cells, oldest at index 0, newest sample enters at the top
   for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
      if (i == HISTORY_DEPTH - 1) begin : g_top
         lcd_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctrl     (ctrl),
            .sample   (req_chan.sample),
            .neighbor (req_chan.sample),
            .entry    (hist[i])
         );
      end else begin : g_mid
         lcd_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctrl     (ctrl),
            .sample   (req_chan.sample),
            .neighbor (hist[i+1]),
            .entry    (hist[i])
         );
      end
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_result_in = rsp_result_ff;
      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_result_in = result;
      end else if (rsp_chan.ready) begin
         rsp_valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_result_ff <= rsp_result_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.screen_on    = rsp_result_ff.screen_on;
   assign rsp_chan.sample_added = rsp_result_ff.sample_added;
   assign rsp_chan.evaluated    = rsp_result_ff.evaluated;

   // a sample never both joins the history and signals screen on
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !(rsp_chan.screen_on && rsp_chan.sample_added))
      else $error("screen_on and sample_added both set");

   // flags only on evaluated transactions
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.evaluated)
      |-> (!rsp_chan.screen_on && !rsp_chan.sample_added))
      else $error("flag set on a transaction that was not evaluated");

   // an accepted transaction shows up in the output register next cycle
   assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_valid_ff && (rsp_result_ff == $past(result))))
      else $error("response register not loaded");

endmodule

/* verif/tb_light_change_detector.sv */
// ----------------------------------------------------------------------------
// Light change detector testbench
// Drives sensor ticks and fill commands through the request channel, predicts
// the detection flags of every transaction from a local model of the history,
// the running sum and the tick counter, and checks each response in order.
// Covers register extremes, decimation changes, stalls on both channels and a
// long receiver hold-off that backs up the request side.
// ----------------------------------------------------------------------------
module tb_light_change_detector;
   import lcd_pkg::*;

   localparam int CYCLE_LIMIT = 100000;
   localparam int HOLD_CYCLES = 300;
   localparam int IDLE_PCT    = 37;
   localparam int SAMPLE_MAX  = (2 ** SAMPLE_W) - 1;
   // Index outside the register map; writes to it must be ignored
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 2'd3;

   logic clock;
   logic reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   lcd_req_if req_if ();
   lcd_rsp_if rsp_if ();

   light_change_detector i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Local copy of detector state and registers
   lcd_cfg_type         model_cfg;
   logic [SAMPLE_W-1:0] model_history [HISTORY_DEPTH];
   logic [SUM_W-1:0]    model_sum;
   logic [TICK_W-1:0]   model_ticks;

   lcd_result_type expected_flags [$];

   int  error_count;
   int  cycle_count;
   int  request_count;
   int  eval_count;
   int  added_count;
   int  screen_on_count;
   bit  sender_idle_en;
   bit  receiver_idle_en;
   int  holds_requested;
   int  holds_served;
   int  hold_left;

   // Clock
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("light_change_detector: mismatch");
         $finish;
      end
   end

   // Predict the flags of one transaction and advance the local state
   function automatic lcd_result_type predict_flags(lcd_cmd_type cmd,
                                                    logic [SAMPLE_W-1:0] smp);
      lcd_result_type flags;
      int avg;
      int diff;
      int next_tick;
      flags = '0;
      if (cmd == CMD_FILL) begin
         for (int i = 0; i < HISTORY_DEPTH; i++) model_history[i] = smp;
         model_sum = SUM_W'(int'(smp) * HISTORY_DEPTH);
      end else begin
         next_tick = int'(model_ticks) + 1;
         if (next_tick < int'(model_cfg.decimation)) begin
            model_ticks = TICK_W'(next_tick);
         end else begin
            model_ticks     = '0;
            flags.evaluated = 1'b1;
            avg  = int'(model_sum) / HISTORY_DEPTH;
            diff = int'(smp) - avg;
            if (diff < int'(model_cfg.add_threshold)) begin
               // shift toward the oldest entry, newest at the top
               model_sum = model_sum - model_history[0];
               for (int i = 0; i < HISTORY_DEPTH - 1; i++)
                  model_history[i] = model_history[i + 1];
               model_history[HISTORY_DEPTH - 1] = smp;
               model_sum          = model_sum + smp;
               flags.sample_added = 1'b1;
            end else if (diff > int'(model_cfg.on_threshold)) begin
               flags.screen_on = 1'b1;
            end
         end
      end
      return flags;
   endfunction

   // Send one transaction; entered and left at a falling edge, valid left high
   task automatic send_request(lcd_cmd_type cmd, logic [SAMPLE_W-1:0] smp);
      while (sender_idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.command <= cmd;
      req_if.sample  <= smp;
      do @(posedge clock); while (!req_if.ready);
      expected_flags.push_back(predict_flags(cmd, smp));
      request_count++;
      @(negedge clock);
   endtask

   // Quiesce the channel, then write one register
   task automatic write_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      req_if.valid <= 1'b0;
      while (expected_flags.size() != 0) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      case (idx)
         CSR_ADD_THRESHOLD: model_cfg.add_threshold = value[SAMPLE_W-1:0];
         CSR_ON_THRESHOLD:  model_cfg.on_threshold  = value[SAMPLE_W-1:0];
         CSR_DECIMATION:    model_cfg.decimation    = value[TICK_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_config(int add_th, int on_th, int dec);
      write_register(CSR_ADD_THRESHOLD, CSR_DATA_W'(add_th));
      write_register(CSR_ON_THRESHOLD, CSR_DATA_W'(on_th));
      write_register(CSR_DECIMATION, CSR_DATA_W'(dec));
   endtask

   // Sample around the current baseline average, clamped to the sensor range
   function automatic logic [SAMPLE_W-1:0] sample_near_average();
      int span;
      int smp;
      span = int'(model_cfg.on_threshold) + 24;
      if (span > SAMPLE_MAX) span = SAMPLE_MAX;
      smp = int'(model_sum) / HISTORY_DEPTH + int'($urandom_range(0, 2 * span)) - span;
      if (smp < 0) smp = 0;
      if (smp > SAMPLE_MAX) smp = SAMPLE_MAX;
      return SAMPLE_W'(smp);
   endfunction

   // Receiver: random stalls, plus a long hold-off when requested
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_if.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (holds_served != holds_requested) begin
         rsp_if.ready <= 1'b0;
         hold_left    <= HOLD_CYCLES - 1;
         holds_served <= holds_served + 1;
      end else if (receiver_idle_en) begin
         rsp_if.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // Response checker
   always @(posedge clock) begin : check_responses
      lcd_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         eval_count      += rsp_if.evaluated;
         added_count     += rsp_if.sample_added;
         screen_on_count += rsp_if.screen_on;
         if (expected_flags.size() == 0) begin
            error_count++;
            $display("%0t: response with nothing expected, actual on=%b added=%b eval=%b",
                     $time, rsp_if.screen_on, rsp_if.sample_added, rsp_if.evaluated);
         end else begin
            want = expected_flags.pop_front();
            if (rsp_if.screen_on !== want.screen_on) begin
               error_count++;
               $display("%0t: screen_on expected %b actual %b",
                        $time, want.screen_on, rsp_if.screen_on);
            end
            if (rsp_if.sample_added !== want.sample_added) begin
               error_count++;
               $display("%0t: sample_added expected %b actual %b",
                        $time, want.sample_added, rsp_if.sample_added);
            end
            if (rsp_if.evaluated !== want.evaluated) begin
               error_count++;
               $display("%0t: evaluated expected %b actual %b",
                        $time, want.evaluated, rsp_if.evaluated);
            end
         end
      end
   end

   // Reset register values: 300 ticks reach the first evaluation
   task automatic test_reset_defaults();
      for (int i = 0; i < 300; i++) begin
         if (i == 100 || i == 200)
            send_request(CMD_FILL, SAMPLE_W'($urandom_range(0, 3)));
         if ($urandom_range(0, 1))
            send_request(CMD_TICK, SAMPLE_W'($urandom_range(0, 16)));
         else
            send_request(CMD_TICK, SAMPLE_W'($urandom_range(0, SAMPLE_MAX)));
      end
   endtask

   // Sample and threshold extremes, decimation zero and one, unmapped index
   task automatic test_corner_cases();
      set_config(6, 10, 1);
      // bit above the decimation width is dropped
      write_register(CSR_DECIMATION, 10'h201);
      send_request(CMD_FILL, 10'd0);
      send_request(CMD_TICK, 10'd1023);
      send_request(CMD_TICK, 10'd0);
      send_request(CMD_FILL, 10'd1023);
      send_request(CMD_TICK, 10'd0);
      send_request(CMD_TICK, 10'd1023);
      // zero add threshold: only a sample below the average joins
      write_register(CSR_ADD_THRESHOLD, 10'd0);
      send_request(CMD_FILL, 10'd500);
      send_request(CMD_TICK, 10'd500);
      send_request(CMD_TICK, 10'd499);
      // top thresholds: full-scale step neither joins nor signals
      write_register(CSR_ADD_THRESHOLD, 10'd1023);
      write_register(CSR_ON_THRESHOLD, 10'd1023);
      send_request(CMD_FILL, 10'd0);
      send_request(CMD_TICK, 10'd1023);
      send_request(CMD_TICK, 10'd1022);
      // on threshold zero
      set_config(0, 0, 0);
      send_request(CMD_FILL, 10'd300);
      send_request(CMD_TICK, 10'd301);
      send_request(CMD_TICK, 10'd300);
      write_register(CSR_UNMAPPED, 10'd5);
      send_request(CMD_TICK, 10'd299);
   endtask

   // Decimation lowered below the running tick count; fill keeps the count
   task automatic test_decimation_lowered();
      set_config(6, 10, 511);
      send_request(CMD_FILL, SAMPLE_W'($urandom_range(0, SAMPLE_MAX)));
      for (int i = 0; i < 60; i++) send_request(CMD_TICK, sample_near_average());
      write_register(CSR_DECIMATION, 10'd3);
      send_request(CMD_TICK, sample_near_average());
      send_request(CMD_TICK, sample_near_average());
      send_request(CMD_FILL, SAMPLE_W'($urandom_range(0, SAMPLE_MAX)));
      send_request(CMD_TICK, sample_near_average());
      send_request(CMD_TICK, sample_near_average());
   endtask

   // Receiver holds off while the sender keeps offering transactions
   task automatic test_backpressure();
      sender_idle_en = 1'b0;
      set_config(8, 20, 1);
      holds_requested++;
      send_request(CMD_FILL, SAMPLE_W'($urandom_range(100, 900)));
      for (int i = 0; i < 80; i++) send_request(CMD_TICK, sample_near_average());
      sender_idle_en = 1'b1;
   endtask

   // Random phase: a fill, then mostly ticks near the average with some fills and noise
   task automatic run_random_phase(int add_th, int on_th, int dec, int n_items);
      int pick;
      set_config(add_th, on_th, dec);
      send_request(CMD_FILL, SAMPLE_W'($urandom_range(0, SAMPLE_MAX)));
      for (int i = 0; i < n_items; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 10)
            send_request(CMD_FILL, SAMPLE_W'($urandom_range(0, SAMPLE_MAX)));
         else if (pick < 18)
            send_request(lcd_cmd_type'($urandom_range(0, 1)),
                         SAMPLE_W'($urandom_range(0, SAMPLE_MAX)));
         else
            send_request(CMD_TICK, sample_near_average());
      end
   endtask

   task automatic test_random_traffic();
      run_random_phase(0, 0, 1, 100);
      run_random_phase(1023, 1023, 1, 100);
      run_random_phase($urandom_range(0, 1023), $urandom_range(0, 40),
                       $urandom_range(2, 5), 100);
      // long stretch without stalls on either side
      sender_idle_en   = 1'b0;
      receiver_idle_en = 1'b0;
      run_random_phase($urandom_range(6, 20), $urandom_range(10, 60), 1, 100);
      sender_idle_en   = 1'b1;
      receiver_idle_en = 1'b1;
      run_random_phase($urandom_range(0, 1023), $urandom_range(0, 1023),
                       $urandom_range(1, 8), 100);
      run_random_phase($urandom_range(0, 30), $urandom_range(0, 30),
                       $urandom_range(1, 3), 100);
   endtask

   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      req_if.valid     = 1'b0;
      req_if.command   = 1'b0;
      req_if.sample    = '0;
      rsp_if.ready     = 1'b0;
      error_count      = 0;
      cycle_count      = 0;
      request_count    = 0;
      eval_count       = 0;
      added_count      = 0;
      screen_on_count  = 0;
      holds_requested  = 0;
      holds_served     = 0;
      hold_left        = 0;
      sender_idle_en   = 1'b1;
      receiver_idle_en = 1'b1;
      model_cfg.add_threshold = ADD_THRESHOLD_RESET;
      model_cfg.on_threshold  = ON_THRESHOLD_RESET;
      model_cfg.decimation    = DECIMATION_RESET;
      for (int i = 0; i < HISTORY_DEPTH; i++) model_history[i] = '0;
      model_sum   = '0;
      model_ticks = '0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_corner_cases();
      test_decimation_lowered();
      test_backpressure();
      test_random_traffic();

      // drain
      req_if.valid <= 1'b0;
      while (expected_flags.size() != 0) @(negedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d transactions over %0d cycles, including a %0d-cycle hold-off.",
               request_count, cycle_count, HOLD_CYCLES);
      $display("Responses: %0d evaluated, %0d joined the history, %0d screen-on.",
               eval_count, added_count, screen_on_count);
      if (error_count == 0 && expected_flags.size() == 0) begin
         $display("light_change_detector: match");
      end else begin
         $display("light_change_detector: mismatch");
      end
      $finish;
   end

endmodule
